// File: hw/rtl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Result kind codes
    typedef logic [1:0] t_kind;

    localparam t_kind KIND_BYTE  = 2'd0;
    localparam t_kind KIND_DONE  = 2'd1;
    localparam t_kind KIND_ERROR = 2'd2;

    // Results caused by one input transfer: up to four bytes, or a single
    // done or error result. last_idx is the number of results minus one.
    typedef struct packed {
        logic [1:0]      last_idx;
        t_kind           kind;
        logic            had_escape;
        logic [3:0][7:0] bytes;
    } t_bundle;

endpackage

`default_nettype wire

// File: hw/rtl/json_string_unescape_utf8_top.sv
// JSON string unescaper: takes the bytes of one quoted string literal, opening
// quote first, and emits the decoded UTF-8 bytes, then a done result (with a
// flag telling whether any escape appeared) or an error result. Each input
// byte is decoded in the cycle it is transferred and its results appear on
// the output in the cycle after. The input takes one byte per cycle while
// each byte yields at most one result and the output is ready; a \uXXXX
// escape that finishes a code point yields up to four bytes, and the input
// then stalls until the last of them is transferred, since the single output
// result buffer holds one byte's results. A stalled output holds off the
// input whether or not the next byte yields a result. After an error, bytes
// are dropped until an input_end transfer returns the block to idle.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_top
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_input_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_out_kind,
    output logic            o_had_escape,
    output logic            o_last
);

    t_bundle bundle;
    logic    load;
    logic    free;
    logic    accept;

    assign o_in_ready = free;
    assign accept     = i_in_valid && free;

    jsu_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_input_end (i_input_end),
        .o_bundle    (bundle),
        .o_load      (load)
    );

    jsu_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept && load),
        .i_bundle     (bundle),
        .o_free       (free),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_kind   (o_out_kind),
        .o_had_escape (o_had_escape),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// File: hw/rtl/jsu_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_input_end,
    output t_bundle         o_bundle,
    output logic            o_load
);

    // Parser phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_BODY     = 3'd1;
    localparam logic [2:0] PH_ESC      = 3'd2;
    localparam logic [2:0] PH_HEX      = 3'd3;
    localparam logic [2:0] PH_PAIR_BS  = 3'd4;
    localparam logic [2:0] PH_PAIR_U   = 3'd5;
    localparam logic [2:0] PH_PAIR_HEX = 3'd6;
    localparam logic [2:0] PH_ERROR    = 3'd7;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b1, 4'(b - 8'h37)};
        end
        return v;
    endfunction

    logic [2:0]  r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_high, n_high;
    logic [2:0]  r_left, n_left;
    logic        r_esc, n_esc;

    logic [4:0]  hv;
    logic [15:0] acc_next;
    logic [2:0]  left_next;
    logic [20:0] cp_pair;
    logic [20:0] cp;
    logic [3:0][7:0] enc_bytes;
    logic [1:0]  enc_last;

    assign hv        = hex_value(i_data_byte);
    assign acc_next  = {r_acc[11:0], hv[3:0]};
    assign left_next = r_left - 3'd1;

    // Join surrogate halves: both offsets are the low ten bits
    assign cp_pair = 21'h10000 + {1'b0, r_high[9:0], acc_next[9:0]};
    assign cp      = (r_phase == PH_PAIR_HEX) ? cp_pair : {5'd0, acc_next};

    // Encode the code point as UTF-8
    always_comb begin
        enc_bytes = '0;
        if (cp < 21'h80) begin
            enc_last     = 2'd0;
            enc_bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            enc_last     = 2'd1;
            enc_bytes[0] = 8'hC0 | {3'd0, cp[10:6]};
            enc_bytes[1] = 8'h80 | {2'd0, cp[5:0]};
        end else if (cp < 21'h10000) begin
            enc_last     = 2'd2;
            enc_bytes[0] = 8'hE0 | {4'd0, cp[15:12]};
            enc_bytes[1] = 8'h80 | {2'd0, cp[11:6]};
            enc_bytes[2] = 8'h80 | {2'd0, cp[5:0]};
        end else begin
            enc_last     = 2'd3;
            enc_bytes[0] = 8'hF0 | {5'd0, cp[20:18]};
            enc_bytes[1] = 8'h80 | {2'd0, cp[17:12]};
            enc_bytes[2] = 8'h80 | {2'd0, cp[11:6]};
            enc_bytes[3] = 8'h80 | {2'd0, cp[5:0]};
        end
    end

    // Next state and results for the byte on the input
    always_comb begin
        logic do_err;
        logic do_byte;
        logic do_enc;
        logic [7:0] out_b;

        n_phase  = r_phase;
        n_acc    = r_acc;
        n_high   = r_high;
        n_left   = r_left;
        n_esc    = r_esc;
        o_bundle = '0;
        o_load   = 1'b0;
        do_err   = 1'b0;
        do_byte  = 1'b0;
        do_enc   = 1'b0;
        out_b    = i_data_byte;

        if (i_input_end) begin
            n_phase = PH_IDLE;
            if (r_phase != PH_IDLE && r_phase != PH_ERROR) begin
                o_load        = 1'b1;
                o_bundle.kind = KIND_ERROR;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_data_byte != CH_QUOTE) begin
                        do_err = 1'b1;
                    end else begin
                        n_esc   = 1'b0;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (i_data_byte == CH_QUOTE) begin
                        n_phase             = PH_IDLE;
                        o_load              = 1'b1;
                        o_bundle.kind       = KIND_DONE;
                        o_bundle.had_escape = r_esc;
                    end else if (i_data_byte == CH_BSL) begin
                        n_esc   = 1'b1;
                        n_phase = PH_ESC;
                    end else if (i_data_byte < 8'h20) begin
                        do_err = 1'b1;
                    end else begin
                        do_byte = 1'b1;
                    end
                end
                PH_ESC: begin
                    n_phase = PH_BODY;
                    unique case (i_data_byte)
                        CH_QUOTE, CH_BSL, CH_SLASH: do_byte = 1'b1;
                        CH_B: begin do_byte = 1'b1; out_b = 8'h08; end
                        CH_F: begin do_byte = 1'b1; out_b = 8'h0C; end
                        CH_N: begin do_byte = 1'b1; out_b = 8'h0A; end
                        CH_R: begin do_byte = 1'b1; out_b = 8'h0D; end
                        CH_T: begin do_byte = 1'b1; out_b = 8'h09; end
                        CH_U: begin
                            n_acc   = 16'd0;
                            n_left  = 3'd4;
                            n_phase = PH_HEX;
                        end
                        default: do_err = 1'b1;
                    endcase
                end
                PH_HEX, PH_PAIR_HEX: begin
                    if (!hv[4]) begin
                        do_err = 1'b1;
                    end else begin
                        n_acc  = acc_next;
                        n_left = left_next;
                        if (left_next == 3'd0) begin
                            if (r_phase == PH_HEX) begin
                                if (acc_next[15:10] == 6'b110110) begin
                                    n_high  = acc_next;
                                    n_phase = PH_PAIR_BS;
                                end else begin
                                    n_phase = PH_BODY;
                                    do_enc  = 1'b1;
                                end
                            end else if (acc_next[15:10] != 6'b110111) begin
                                do_err = 1'b1;
                            end else begin
                                n_phase = PH_BODY;
                                do_enc  = 1'b1;
                            end
                        end
                    end
                end
                PH_PAIR_BS: begin
                    if (i_data_byte != CH_BSL) begin
                        do_err = 1'b1;
                    end else begin
                        n_phase = PH_PAIR_U;
                    end
                end
                PH_PAIR_U: begin
                    if (i_data_byte != CH_U) begin
                        do_err = 1'b1;
                    end else begin
                        n_acc   = 16'd0;
                        n_left  = 3'd4;
                        n_phase = PH_PAIR_HEX;
                    end
                end
                PH_ERROR: n_phase = PH_ERROR;
                default:  n_phase = PH_ERROR;
            endcase

            if (do_err) begin
                n_phase       = PH_ERROR;
                o_load        = 1'b1;
                o_bundle.kind = KIND_ERROR;
            end else if (do_byte) begin
                o_load            = 1'b1;
                o_bundle.bytes[0] = out_b;
            end else if (do_enc) begin
                o_load            = 1'b1;
                o_bundle.bytes    = enc_bytes;
                o_bundle.last_idx = enc_last;
            end
        end
    end

    // Advance parser state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= 16'd0;
            r_high  <= 16'd0;
            r_left  <= 3'd0;
            r_esc   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_high  <= n_high;
            r_left  <= n_left;
            r_esc   <= n_esc;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/jsu_outbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module jsu_outbuf
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_bundle    i_bundle,
    output logic            o_free,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [1:0]      o_out_kind,
    output logic            o_had_escape,
    output logic            o_last
);

    t_bundle    r_bundle;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       take;
    logic       done_take;

    assign take      = r_busy && i_out_ready;
    assign done_take = take && o_last;
    assign o_free    = !r_busy || done_take;

    assign o_out_valid  = r_busy;
    assign o_out_byte   = r_bundle.bytes[r_idx];
    assign o_out_kind   = r_bundle.kind;
    assign o_had_escape = r_bundle.had_escape;
    assign o_last       = (r_idx == r_bundle.last_idx);

    // Hold the result payload of the latest producing transfer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

    // Step through the held results one transfer at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (done_take) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= r_bundle.last_idx)
        else $error("result index past end of bundle");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("bundle loaded over undelivered results");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_take && !i_load) |=> !r_busy)
        else $error("buffer still busy after last result transfer");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_out_ready) |=> ($stable(r_idx) && r_busy))
        else $error("result index moved during stall");
`endif

endmodule

`default_nettype wire
